FILE: rtl/core/gppc_pkg.sv
// Shared widths, constants, types, arctangent table and rounding helpers of the proximity check.
package gppc_pkg;

  // Field widths
  localparam int ANGLE_FRAC_BITS = 20;
  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int ALT_W  = 27;
  localparam int PROX_W = 26;

  // Angles are carried in degrees Q24 inside the lanes
  localparam int ANG_SHIFT = 24 - ANGLE_FRAC_BITS;
  localparam int Z_W       = 33;
  localparam int TRIG_W    = 34;
  localparam int Q_FRAC    = 30;

  // Pipeline geometry
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam int ROOT_W       = 31;
  localparam int RAD_W        = ROOT_W + Q_FRAC;
  localparam int SQRT_STEPS   = (RAD_W + 1) / 2;
  localparam int NUM_W        = 63;
  localparam int QUO_W        = 34;
  localparam int DIV_STEPS    = QUO_W;
  localparam int REM_W        = ROOT_W;
  localparam int DLY_TRIG     = 2 + SQRT_STEPS + 1 + DIV_STEPS;
  localparam int DLY_ALT      = CORDIC_LAT + DLY_TRIG;
  localparam int LANE_LAT     = 1 + CORDIC_LAT + DLY_TRIG + 3;
  localparam int PIPE_LAT     = LANE_LAT + 2;

  // Datapath widths
  localparam int N14_W   = QUO_W - 6 + 2;
  localparam int R_W     = 32;
  localparam int COORD_W = 28;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W - 1;
  localparam int SUM_W   = SQ_W + 2;
  localparam int PROD_W  = 68;
  localparam int RQ_W    = PROD_W - Q_FRAC;

  // Constants
  localparam logic signed [TRIG_W-1:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic signed [Z_W-1:0]    DEG90_Q24    = 33'sd1509949440;
  localparam logic signed [Z_W-1:0]    DEG180_Q24   = 33'sd3019898880;
  localparam logic signed [R_W-1:0]    ONE_Q30      = 32'sd1073741824;
  localparam logic signed [R_W-1:0]    E2_Q30       = 32'sd7188036;
  localparam logic signed [R_W-1:0]    OME2_Q30     = ONE_Q30 - E2_Q30;
  localparam logic [NUM_W-1:0]         A_Q20        = 63'd6687961383;
  localparam logic [NUM_W-1:0]         NUM_BASE     = A_Q20 << Q_FRAC;
  localparam logic [PROX_W-1:0]        PROX_RESET   = 26'd10240;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sl;
    logic signed [TRIG_W-1:0] cl;
    logic signed [TRIG_W-1:0] so;
    logic signed [TRIG_W-1:0] co;
  } trig_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // atan(2^-i) in degrees Q24
  function automatic logic signed [Z_W-1:0] cordic_atan(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:  v = 33'sd754974720;
      5'd1:  v = 33'sd445687602;
      5'd2:  v = 33'sd235489088;
      5'd3:  v = 33'sd119537938;
      5'd4:  v = 33'sd60000934;
      5'd5:  v = 33'sd30029717;
      5'd6:  v = 33'sd15018523;
      5'd7:  v = 33'sd7509720;
      5'd8:  v = 33'sd3754917;
      5'd9:  v = 33'sd1877466;
      5'd10: v = 33'sd938734;
      5'd11: v = 33'sd469367;
      5'd12: v = 33'sd234684;
      5'd13: v = 33'sd117342;
      5'd14: v = 33'sd58671;
      5'd15: v = 33'sd29335;
      5'd16: v = 33'sd14668;
      5'd17: v = 33'sd7334;
      5'd18: v = 33'sd3667;
      5'd19: v = 33'sd1833;
      5'd20: v = 33'sd917;
      5'd21: v = 33'sd458;
      5'd22: v = 33'sd229;
      5'd23: v = 33'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up and drop 30 fraction bits of a product
  function automatic logic signed [RQ_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) << (Q_FRAC - 1));
    return t[PROD_W-1:Q_FRAC];
  endfunction

  // Round half up from km Q14 to km Q10
  function automatic logic signed [RQ_W-5:0] rnd_q10(input logic signed [RQ_W-1:0] v);
    logic signed [RQ_W-1:0] t;
    t = v + RQ_W'(8);
    return t[RQ_W-1:4];
  endfunction

endpackage

FILE: rtl/core/gppc_cordic.sv
// Pipelined rotation CORDIC: sine and cosine of a folded angle, one step per stage.
module gppc_cordic import gppc_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [Z_W-1:0]    z_i,
  input  logic                     flip_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  logic signed [TRIG_W-1:0] x_r   [CORDIC_STEPS];
  logic signed [TRIG_W-1:0] y_r   [CORDIC_STEPS];
  logic signed [Z_W-1:0]    z_r   [CORDIC_STEPS];
  logic                     flip_r[CORDIC_STEPS];
  logic signed [TRIG_W-1:0] x_nxt [CORDIC_STEPS];
  logic signed [TRIG_W-1:0] y_nxt [CORDIC_STEPS];
  logic signed [Z_W-1:0]    z_nxt [CORDIC_STEPS];
  logic                     flip_nxt[CORDIC_STEPS];
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  // One micro-rotation per stage
  always_comb begin
    logic signed [TRIG_W-1:0] xi, yi;
    logic signed [Z_W-1:0]    zi;
    logic                     fi;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        xi = GAIN_INV_Q30;
        yi = '0;
        zi = z_i;
        fi = flip_i;
      end else begin
        xi = x_r[i-1];
        yi = y_r[i-1];
        zi = z_r[i-1];
        fi = flip_r[i-1];
      end
      if (!zi[Z_W-1]) begin
        x_nxt[i] = xi - (yi >>> i);
        y_nxt[i] = yi + (xi >>> i);
        z_nxt[i] = zi - cordic_atan(5'(i));
      end else begin
        x_nxt[i] = xi + (yi >>> i);
        y_nxt[i] = yi - (xi >>> i);
        z_nxt[i] = zi + cordic_atan(5'(i));
      end
      flip_nxt[i] = fi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_r[i]    <= x_nxt[i];
        y_r[i]    <= y_nxt[i];
        z_r[i]    <= z_nxt[i];
        flip_r[i] <= flip_nxt[i];
      end
    end
  end

  // Undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en) begin
      if (flip_r[CORDIC_STEPS-1]) begin
        sin_r <= -y_r[CORDIC_STEPS-1];
        cos_r <= -x_r[CORDIC_STEPS-1];
      end else begin
        sin_r <= y_r[CORDIC_STEPS-1];
        cos_r <= x_r[CORDIC_STEPS-1];
      end
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

FILE: rtl/core/gppc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module gppc_isqrt import gppc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0] n_r   [SQRT_STEPS];
  logic [RAD_W-1:0] r_r   [SQRT_STEPS];
  logic [RAD_W-1:0] n_nxt [SQRT_STEPS];
  logic [RAD_W-1:0] r_nxt [SQRT_STEPS];

  // Digit-by-digit: try to subtract r + b, b a fixed power of four per stage
  always_comb begin
    logic [RAD_W-1:0] ni, ri;
    logic [RAD_W:0]   bk, trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        ni = rad_i;
        ri = '0;
      end else begin
        ni = n_r[k-1];
        ri = r_r[k-1];
      end
      bk    = (RAD_W+1)'(1) << (2 * (SQRT_STEPS - 1 - k));
      trial = {1'b0, ri} + bk;
      if ({1'b0, ni} >= trial) begin
        n_nxt[k] = RAD_W'({1'b0, ni} - trial);
        r_nxt[k] = RAD_W'(({1'b0, ri} >> 1) + bk);
      end else begin
        n_nxt[k] = ni;
        r_nxt[k] = ri >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        n_r[k] <= n_nxt[k];
        r_r[k] <= r_nxt[k];
      end
    end
  end

  assign root_o = r_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

FILE: rtl/core/gppc_ndiv.sv
// Pipelined restoring divider for the prime-vertical radius a*2^30/root.
module gppc_ndiv import gppc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] root_i,
  output logic [QUO_W-1:0]  quo_o
);

  logic [REM_W-1:0]  rem_p_r;
  logic [QUO_W-1:0]  lo_p_r;
  logic [ROOT_W-1:0] den_p_r;
  logic [NUM_W-1:0]  num;

  logic [REM_W-1:0]  rem_r  [DIV_STEPS];
  logic [QUO_W-1:0]  quo_r  [DIV_STEPS];
  logic [QUO_W-1:0]  lo_r   [DIV_STEPS];
  logic [ROOT_W-1:0] den_r  [DIV_STEPS];
  logic [REM_W-1:0]  rem_nxt[DIV_STEPS];
  logic [QUO_W-1:0]  quo_nxt[DIV_STEPS];

  // Rounded numerator; root stays above 2^29, so the quotient fits QUO_W bits
  assign num = NUM_BASE + NUM_W'(root_i >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_p_r <= REM_W'(num[NUM_W-1:QUO_W]);
      lo_p_r  <= num[QUO_W-1:0];
      den_p_r <= (root_i == '0) ? ROOT_W'(1) : root_i;
    end
  end

  // One quotient bit per stage
  always_comb begin
    logic [REM_W-1:0]  ri;
    logic [QUO_W-1:0]  qi, li;
    logic [ROOT_W-1:0] di;
    logic [REM_W:0]    t;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        ri = rem_p_r;
        qi = '0;
        li = lo_p_r;
        di = den_p_r;
      end else begin
        ri = rem_r[j-1];
        qi = quo_r[j-1];
        li = lo_r[j-1];
        di = den_r[j-1];
      end
      t = {ri, li[DIV_STEPS-1-j]};
      if (t >= {1'b0, di}) begin
        rem_nxt[j] = REM_W'(t - {1'b0, di});
        quo_nxt[j] = {qi[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[j] = REM_W'(t);
        quo_nxt[j] = {qi[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_r[j] <= rem_nxt[j];
        quo_r[j] <= quo_nxt[j];
        lo_r[j]  <= (j == 0) ? lo_p_r : lo_r[j-1];
        den_r[j] <= (j == 0) ? den_p_r : den_r[j-1];
      end
    end
  end

  assign quo_o = quo_r[DIV_STEPS-1];

endmodule

FILE: rtl/core/gppc_lane.sv
// One conversion lane: geodetic latitude/longitude/altitude to WGS84 ECEF in km Q10.
module gppc_lane import gppc_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [LAT_W-1:0] lat_i,
  input  logic signed [LON_W-1:0] lon_i,
  input  logic signed [ALT_W-1:0] alt_i,
  output point_t                  pt_o
);

  localparam logic signed [LAT_W-1:0] LAT_LIM = LAT_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [LON_W-1:0] LON_LIM = LON_W'(180 << ANGLE_FRAC_BITS);

  // Clamp and fold
  logic signed [LAT_W-1:0] lat_c;
  logic signed [LON_W-1:0] lon_c;
  logic signed [Z_W-1:0]   lat_s, lon_s, lat_z_nxt, lon_z_nxt;
  logic                    lat_flip_nxt, lon_flip_nxt;
  logic signed [Z_W-1:0]   lat_z_r, lon_z_r;
  logic                    lat_flip_r, lon_flip_r;
  logic [ALT_W-1:0]        alt_r;

  always_comb begin
    if (lat_i > LAT_LIM)       lat_c = LAT_LIM;
    else if (lat_i < -LAT_LIM) lat_c = -LAT_LIM;
    else                       lat_c = lat_i;
    if (lon_i > LON_LIM)       lon_c = LON_LIM;
    else if (lon_i < -LON_LIM) lon_c = -LON_LIM;
    else                       lon_c = lon_i;
    lat_s = Z_W'(lat_c) <<< ANG_SHIFT;
    lon_s = Z_W'(lon_c) <<< ANG_SHIFT;

    lat_z_nxt    = lat_s;
    lat_flip_nxt = 1'b0;
    if (lat_s > DEG90_Q24) begin
      lat_z_nxt    = lat_s - DEG180_Q24;
      lat_flip_nxt = 1'b1;
    end else if (lat_s < -DEG90_Q24) begin
      lat_z_nxt    = lat_s + DEG180_Q24;
      lat_flip_nxt = 1'b1;
    end

    lon_z_nxt    = lon_s;
    lon_flip_nxt = 1'b0;
    if (lon_s > DEG90_Q24) begin
      lon_z_nxt    = lon_s - DEG180_Q24;
      lon_flip_nxt = 1'b1;
    end else if (lon_s < -DEG90_Q24) begin
      lon_z_nxt    = lon_s + DEG180_Q24;
      lon_flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat_z_r    <= lat_z_nxt;
      lat_flip_r <= lat_flip_nxt;
      lon_z_r    <= lon_z_nxt;
      lon_flip_r <= lon_flip_nxt;
      alt_r      <= alt_i;
    end
  end

  // Sine and cosine of both angles
  logic signed [TRIG_W-1:0] lat_sin, lat_cos, lon_sin, lon_cos;

  gppc_cordic u_cordic_lat (
    .clk    (clk),
    .en     (en),
    .z_i    (lat_z_r),
    .flip_i (lat_flip_r),
    .sin_o  (lat_sin),
    .cos_o  (lat_cos)
  );

  gppc_cordic u_cordic_lon (
    .clk    (clk),
    .en     (en),
    .z_i    (lon_z_r),
    .flip_i (lon_flip_r),
    .sin_o  (lon_sin),
    .cos_o  (lon_cos)
  );

  // sin^2 then w = 1 - e^2 sin^2
  logic signed [R_W-1:0] s2_r;
  logic [ROOT_W-1:0]     w_r;
  logic signed [R_W-1:0] w_nxt;

  assign w_nxt = ONE_Q30 - R_W'(rnd_q30(PROD_W'(E2_Q30) * PROD_W'(s2_r)));

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= R_W'(rnd_q30(PROD_W'(lat_sin) * PROD_W'(lat_sin)));
      w_r  <= w_nxt[ROOT_W-1:0];
    end
  end

  // N = a / sqrt(w) through the root and divide pipelines
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0]  quo;

  gppc_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  ({w_r, {Q_FRAC{1'b0}}}),
    .root_o (root)
  );

  gppc_ndiv u_ndiv (
    .clk    (clk),
    .en     (en),
    .root_i (root),
    .quo_o  (quo)
  );

  // Delay lines that keep trig and altitude aligned with N
  trig_t            trig_dl_r[DLY_TRIG];
  logic [ALT_W-1:0] alt_dl_r [DLY_ALT];

  always_ff @(posedge clk) begin
    if (en) begin
      trig_dl_r[0] <= '{sl: lat_sin, cl: lat_cos, so: lon_sin, co: lon_cos};
      for (int k = 1; k < DLY_TRIG; k++) trig_dl_r[k] <= trig_dl_r[k-1];
      alt_dl_r[0] <= alt_r;
      for (int k = 1; k < DLY_ALT; k++) alt_dl_r[k] <= alt_dl_r[k-1];
    end
  end

  // N to Q14, radius N+h and altitude in Q14
  logic [QUO_W:0]          n_sum;
  logic signed [ALT_W+3:0] alt14_d;
  logic signed [N14_W-1:0] n14_r;
  logic signed [R_W-1:0]   r_r;
  logic signed [ALT_W+3:0] alt14_n_r;
  trig_t                   trig_n_r;

  assign n_sum   = {1'b0, quo} + (QUO_W+1)'(32);
  assign alt14_d = {alt_dl_r[DLY_ALT-1], 4'b0000};

  always_ff @(posedge clk) begin
    if (en) begin
      n14_r     <= {1'b0, n_sum[QUO_W:6]};
      r_r       <= R_W'(signed'({2'b00, n_sum[QUO_W:6]})) + R_W'(alt14_d);
      alt14_n_r <= alt14_d;
      trig_n_r  <= trig_dl_r[DLY_TRIG-1];
    end
  end

  // r*cos(lat) and N(1-e^2)+h
  logic signed [R_W-1:0]    rc_r, rz_r;
  logic signed [TRIG_W-1:0] co_p_r, so_p_r, sl_p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rc_r   <= R_W'(rnd_q30(PROD_W'(r_r) * PROD_W'(trig_n_r.cl)));
      rz_r   <= R_W'(rnd_q30(PROD_W'(n14_r) * PROD_W'(OME2_Q30))) + R_W'(alt14_n_r);
      co_p_r <= trig_n_r.co;
      so_p_r <= trig_n_r.so;
      sl_p_r <= trig_n_r.sl;
    end
  end

  // Final coordinates, km Q10
  point_t pt_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r.x <= COORD_W'(rnd_q10(rnd_q30(PROD_W'(rc_r) * PROD_W'(co_p_r))));
      pt_r.y <= COORD_W'(rnd_q10(rnd_q30(PROD_W'(rc_r) * PROD_W'(so_p_r))));
      pt_r.z <= COORD_W'(rnd_q10(rnd_q30(PROD_W'(rz_r) * PROD_W'(sl_p_r))));
    end
  end

  assign pt_o = pt_r;

endmodule

FILE: rtl/core/geodetic_pairwise_proximity_check_top.sv
// Top level: two conversion lanes, distance merge, sticky hit flag and output register.
// Takes one waypoint/satellite word per clock while not stalled and converts both
// positions in two identical, fully pipelined lanes (CORDIC sine/cosine, square root
// and divider for the prime-vertical radius); the merge squares and sums the coordinate
// differences and compares against proximity squared. Each lane holds the 24-step
// CORDIC, the 31-stage root and the 35-stage divider; a word marked last has its run's
// any_close flag registered into the output register. The pipeline keeps flowing while
// a result waits and stalls only when a last word reaches the end while that register
// is still full and out_ready is low. The proximity register resets to 10 km; the user
// is to write it only while idle, and the block itself does not enforce this.
module geodetic_pairwise_proximity_check_top import gppc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [LAT_W-1:0]  in_wp_lat,
  input  logic signed [LON_W-1:0]  in_wp_lon,
  input  logic signed [ALT_W-1:0]  in_wp_alt,
  input  logic signed [LAT_W-1:0]  in_sat_lat,
  input  logic signed [LON_W-1:0]  in_sat_lon,
  input  logic signed [ALT_W-1:0]  in_sat_alt,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_any_close,
  input  logic                     cfg_wr_en,
  input  logic [PROX_W-1:0]        cfg_wr_data
);

  localparam int END = PIPE_LAT - 1;

  logic adv;
  logic vld_r [PIPE_LAT];
  logic last_r[PIPE_LAT];
  logic out_valid_r, out_any_close_r, hit_seen_r;

  // Stall only when a run result meets a full output register that is not being read
  assign adv      = !(vld_r[END] && last_r[END] && out_valid_r && !out_ready);
  assign in_ready = adv;

  // Proximity register and its square
  logic [PROX_W-1:0]   prox_r;
  logic [2*PROX_W-1:0] prox_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prox_r <= PROX_RESET;
    end else if (cfg_wr_en) begin
      prox_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    prox_sq_r <= prox_r * prox_r;
  end

  // Word tracking along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r[0] <= in_last;
      for (int k = 1; k < PIPE_LAT; k++) last_r[k] <= last_r[k-1];
    end
  end

  // Conversion lanes
  point_t wp_pt, sat_pt;

  gppc_lane u_lane_wp (
    .clk   (clk),
    .en    (adv),
    .lat_i (in_wp_lat),
    .lon_i (in_wp_lon),
    .alt_i (in_wp_alt),
    .pt_o  (wp_pt)
  );

  gppc_lane u_lane_sat (
    .clk   (clk),
    .en    (adv),
    .lat_i (in_sat_lat),
    .lon_i (in_sat_lon),
    .alt_i (in_sat_alt),
    .pt_o  (sat_pt)
  );

  // Merge: squared differences, then sum and compare
  logic [SQ_W-1:0]  sqx_nxt, sqy_nxt, sqz_nxt;
  logic [SQ_W-1:0]  sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0] d2;
  logic             hit_r;

  always_comb begin
    logic signed [DIFF_W-1:0]   dx, dy, dz;
    logic signed [2*DIFF_W-1:0] px, py, pz;
    dx = DIFF_W'(sat_pt.x) - DIFF_W'(wp_pt.x);
    dy = DIFF_W'(sat_pt.y) - DIFF_W'(wp_pt.y);
    dz = DIFF_W'(sat_pt.z) - DIFF_W'(wp_pt.z);
    px = (2*DIFF_W)'(dx) * (2*DIFF_W)'(dx);
    py = (2*DIFF_W)'(dy) * (2*DIFF_W)'(dy);
    pz = (2*DIFF_W)'(dz) * (2*DIFF_W)'(dz);
    sqx_nxt = px[SQ_W-1:0];
    sqy_nxt = py[SQ_W-1:0];
    sqz_nxt = pz[SQ_W-1:0];
  end

  assign d2 = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
      sqz_r <= sqz_nxt;
      hit_r <= d2 < SUM_W'(prox_sq_r);
    end
  end

  // Sticky flag and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (adv && vld_r[END]) begin
        if (last_r[END]) begin
          out_valid_r <= 1'b1;
          hit_seen_r  <= 1'b0;
        end else begin
          hit_seen_r <= hit_seen_r | hit_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[END] && last_r[END]) out_any_close_r <= hit_seen_r | hit_r;
  end

  assign out_valid     = out_valid_r;
  assign out_any_close = out_any_close_r;

endmodule
